[src/pvec_pkg.sv]
// Package for the packed integer vector block: widths, register indexes,
// transaction structs and the control/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package pvec_pkg;

   localparam int DATA_W          = 64;
   localparam int INDEX_W         = 16;
   localparam int FW_W            = 7;
   localparam int COUNT_W         = 17;
   localparam int CSR_IDX_W       = 1;
   localparam int CSR_DATA_W      = 17;
   // index * width: 16 + 7 bits; word number is that over 64
   localparam int BIT_W           = INDEX_W + FW_W;
   localparam int LW_W            = BIT_W - 6;
   localparam int STORE_WORDS_DEF = 1024;

   localparam logic [FW_W-1:0]      FIELD_WIDTH_RST   = 7'd8;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_WIDTH   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEMENT_COUNT = 1'b1;
   localparam logic                 CMD_READ          = 1'b0;
   localparam logic                 CMD_WRITE         = 1'b1;

   typedef struct packed {
      logic               command;
      logic [INDEX_W-1:0] index;
      logic [DATA_W-1:0]  write_value;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_value;
      logic              status;
   } rsp_type;

   typedef struct packed {
      logic load;     // latch request
      logic mul;      // bit position = index * width
      logic rd_lo;    // read first word
      logic rd_hi;    // read second word
      logic cap_lo;   // capture first word
      logic cap_hi;   // capture second word
      logic wr_lo;    // write merged first word
      logic wr_hi;    // write merged second word
      logic respond;  // load response register
   } dp_cmd_type;

   typedef struct packed {
      logic fail;
      logic spans;
      logic is_write;
   } dp_stat_type;

endpackage

`default_nettype wire

[src/pvec_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pvec_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/pvec_ctrl.sv]
// Controller for the packed integer vector: sequences bounds check, word reads
// and read-modify-write. Depends on pvec_pkg.
`default_nettype none

module pvec_ctrl
   import pvec_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire dp_stat_type stat,
   output dp_cmd_type       cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MUL    = 3'd1;
   localparam logic [2:0] ST_CHK    = 3'd2;
   localparam logic [2:0] ST_RD_HI  = 3'd3;
   localparam logic [2:0] ST_CAP_HI = 3'd4;
   localparam logic [2:0] ST_FIN    = 3'd5;
   localparam logic [2:0] ST_WR_HI  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (stat.fail) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.rd_lo = 1'b1;
               state_in  = ST_RD_HI;
            end
         end
         ST_RD_HI: begin
            cmd.cap_lo = 1'b1;
            cmd.rd_hi  = stat.spans;
            state_in   = ST_CAP_HI;
         end
         ST_CAP_HI: begin
            cmd.cap_hi = 1'b1;
            state_in   = ST_FIN;
         end
         ST_FIN: begin
            if (!stat.is_write) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end else if (stat.spans) begin
               cmd.wr_lo = 1'b1;
               state_in  = ST_WR_HI;
            end else begin
               cmd.wr_lo   = 1'b1;
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_WR_HI: begin
            cmd.wr_hi   = 1'b1;
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

[src/pvec_dp.sv]
// Datapath for the packed integer vector: config registers, address math,
// field extract/merge, word store RAM and response register.
// Depends on pvec_pkg and pvec_ram.
`default_nettype none

module pvec_dp
   import pvec_pkg::*;
#(
   parameter int STORE_WORDS = STORE_WORDS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire req_type               req_data,
   input  wire dp_cmd_type            cmd,
   output dp_stat_type                stat,
   input  wire logic                  csr_wr,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                       rsp_valid,
   output rsp_type                    rsp_data
);

   localparam int AW = $clog2(STORE_WORDS);

   logic [FW_W-1:0]    fw_ff;
   logic [COUNT_W-1:0] count_ff;
   req_type            req_ff;
   logic [BIT_W-1:0]   bit_ff;
   logic [DATA_W-1:0]  lo_ff;
   logic [DATA_W-1:0]  hi_ff;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;
   logic               rsp_valid_ff;

   logic [FW_W-1:0]   w_eff;
   logic [DATA_W-1:0] mask;
   logic [DATA_W-1:0] mask_hi;
   logic [DATA_W-1:0] val_m;
   logic [5:0]        off;
   logic [6:0]        off_inv;
   logic [6:0]        hi_bits;
   logic [7:0]        end_pos;
   logic [BIT_W-1:0]  last_bit;
   logic [AW-1:0]     word_addr;
   logic [AW-1:0]     word_next;
   logic [DATA_W-1:0] rd_val;
   logic [DATA_W-1:0] lo_merge;
   logic [DATA_W-1:0] hi_merge;
   logic [DATA_W-1:0] ram_rd;
   logic [AW-1:0]     ram_rd_addr;
   logic [AW-1:0]     ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;

   // width 0 behaves as 1, above 64 as 64
   always_comb begin
      if (fw_ff == '0) begin
         w_eff = 7'd1;
      end else if (fw_ff > 7'd64) begin
         w_eff = 7'd64;
      end else begin
         w_eff = fw_ff;
      end
   end

   assign mask = (w_eff == 7'd64) ? '1 : ((DATA_W'(1) << w_eff) - DATA_W'(1));
   assign val_m = req_ff.write_value & mask;

   assign off      = bit_ff[5:0];
   assign off_inv  = 7'd64 - {1'b0, off};
   assign end_pos  = {2'b00, off} + {1'b0, w_eff};
   assign hi_bits  = end_pos[6:0] - 7'd64;
   assign mask_hi  = (DATA_W'(1) << hi_bits[5:0]) - DATA_W'(1);
   assign last_bit = bit_ff + BIT_W'(w_eff) - BIT_W'(1);

   assign word_addr = bit_ff[AW+5:6];
   assign word_next = word_addr + AW'(1);

   assign stat.spans    = (end_pos > 8'd64);
   assign stat.is_write = (req_ff.command == CMD_WRITE);
   assign stat.fail     = ({1'b0, req_ff.index} >= count_ff)
                        || (last_bit[BIT_W-1:6] >= LW_W'(STORE_WORDS));

   always_comb begin
      rd_val = lo_ff >> off;
      if (stat.spans) begin
         rd_val = rd_val | (hi_ff << off_inv);
      end
      rd_val = rd_val & mask;
   end

   assign lo_merge = (lo_ff & ~(mask << off)) | (val_m << off);
   assign hi_merge = (hi_ff & ~mask_hi) | (val_m >> off_inv);

   always_comb begin
      rsp_in.status     = stat.fail;
      rsp_in.read_value = (stat.fail || stat.is_write) ? '0 : rd_val;
   end

   assign ram_rd_addr = cmd.rd_hi ? word_next : word_addr;
   assign ram_wr_addr = cmd.wr_hi ? word_next : word_addr;
   assign ram_wr_data = cmd.wr_hi ? hi_merge : lo_merge;

   pvec_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_lo | cmd.wr_hi),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_lo | cmd.rd_hi),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff        <= FIELD_WIDTH_RST;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            case (csr_index)
               CSR_FIELD_WIDTH:   fw_ff    <= csr_wdata[FW_W-1:0];
               CSR_ELEMENT_COUNT: count_ff <= csr_wdata[COUNT_W-1:0];
               default: begin
               end
            endcase
         end
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.mul) begin
         bit_ff <= BIT_W'(req_ff.index) * BIT_W'(w_eff);
      end
      if (cmd.cap_lo) begin
         lo_ff <= ram_rd;
      end
      if (cmd.cap_hi) begin
         hi_ff <= ram_rd;
      end
      if (cmd.respond) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[src/packed_int_vector_access.sv]
// Top level of the packed integer vector: read/write of bit-packed elements in a
// 64-bit word store. Depends on pvec_pkg, pvec_ctrl, pvec_dp.
//
//   channel   ports                                   direction  handshake
//   request   start, busy, req_data                   in         start & !busy
//   response  rsp_valid, rsp_data                     out        strobe, one cycle
//   csr       csr_valid, csr_ready, csr_index, csr_wdata  in     valid & ready
//
// A rejected transaction responds after the index multiply and bounds check; a read
// after the word reads and captures; a write also writes the merged first word, and
// the second in a further state when the field spans two words. The next request is
// taken only once busy drops; the word RAM moves one word per cycle.
// Reset idles the state machine, sets field width 8 and element count 0; the store is not cleared.
// The receiver cannot stall; csr_ready is always high.
`default_nettype none

module packed_int_vector_access
   import pvec_pkg::*;
#(
   parameter int STORE_WORDS = STORE_WORDS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   pvec_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   pvec_dp #(
      .STORE_WORDS (STORE_WORDS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .csr_wr    (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[src/pvec_check.sv]
// Port-level checker for packed_int_vector_access, bound to the top level.
// Depends on pvec_pkg.
`default_nettype none

module pvec_check
   import pvec_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_data
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after request accept");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while busy");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |-> rsp_data.read_value == '0)
      else $error("rejected transaction with nonzero read value");

endmodule

bind packed_int_vector_access pvec_check u_check (.*);

`default_nettype wire
